// ===== sv/fbs_pkg.sv =====
// ----------------------------------------------------------------------------
// fbs_pkg
// Command codes, the queued command and the result word of the scrolling
// framebuffer.
// ----------------------------------------------------------------------------
package fbs_pkg;

  localparam int unsigned SHIFT_COLS = 4;

  typedef enum logic [2:0] {
    KIND_TOGGLE  = 3'd0,
    KIND_READ    = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_SDOWN   = 3'd3,
    KIND_SLEFT   = 3'd4,
    KIND_SRIGHT  = 3'd5,
    KIND_HIGHRES = 3'd6,
    KIND_LOWRES  = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] rows;
    logic       hr;
  } cmd_t;

  typedef struct packed {
    logic high_res;
    logic pixel_value;
    logic collision;
  } res_t;

endpackage

// ===== sv/fbs_ram.sv =====
// ----------------------------------------------------------------------------
// fbs_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbs_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wen_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     ren_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ren_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fbs_fifo.sv =====
// ----------------------------------------------------------------------------
// fbs_fifo
// Short register queue that carries classified commands to the back end.
// ----------------------------------------------------------------------------
module fbs_fifo #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= din_i;
    end
  end

endmodule

// ===== sv/fbs_front.sv =====
// ----------------------------------------------------------------------------
// fbs_front
// Accepts commands, wraps the coordinates to the resolution in force and
// tracks the resolution that each command leaves behind.
// ----------------------------------------------------------------------------
module fbs_front import fbs_pkg::*; #(
  parameter int unsigned LOW_WIDTH   = 64,
  parameter int unsigned LOW_HEIGHT  = 32,
  parameter int unsigned HIGH_WIDTH  = 128,
  parameter int unsigned HIGH_HEIGHT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic                           room_i,
  input  logic [2:0]                     kind_i,
  input  logic [7:0]                     x_i,
  input  logic [7:0]                     y_i,
  input  logic [3:0]                     rows_i,
  output logic                           ready_o,
  output logic                           push_o,
  output cmd_t                           cmd_o,
  output logic [$clog2(HIGH_WIDTH)-1:0]  col_o,
  output logic [$clog2(HIGH_HEIGHT)-1:0] row_o
);

  localparam int unsigned COL_W = $clog2(HIGH_WIDTH);
  localparam int unsigned ROW_W = $clog2(HIGH_HEIGHT);

  logic [COL_W-1:0] xlo_tab [256];
  logic [COL_W-1:0] xhi_tab [256];
  logic [ROW_W-1:0] ylo_tab [256];
  logic [ROW_W-1:0] yhi_tab [256];
  logic             hr_q, hr_d;
  kind_e            kind;

  for (genvar i = 0; i < 256; i++) begin : g_wrap
    assign xlo_tab[i] = COL_W'(i % LOW_WIDTH);
    assign xhi_tab[i] = COL_W'(i % HIGH_WIDTH);
    assign ylo_tab[i] = ROW_W'(i % LOW_HEIGHT);
    assign yhi_tab[i] = ROW_W'(i % HIGH_HEIGHT);
  end

  assign kind    = kind_e'(kind_i);
  assign ready_o = room_i;
  assign push_o  = valid_i && room_i;

  always_comb begin
    hr_d = hr_q;
    unique case (kind)
      KIND_HIGHRES: hr_d = 1'b1;
      KIND_LOWRES:  hr_d = 1'b0;
      default:      hr_d = hr_q;
    endcase
  end

  assign cmd_o.kind = kind;
  assign cmd_o.rows = rows_i;
  assign cmd_o.hr   = hr_d;
  assign col_o      = hr_q ? xhi_tab[x_i] : xlo_tab[x_i];
  assign row_o      = hr_q ? yhi_tab[y_i] : ylo_tab[y_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_q <= 1'b0;
    end else if (push_o) begin
      hr_q <= hr_d;
    end
  end

endmodule

// ===== sv/fbs_back.sv =====
// ----------------------------------------------------------------------------
// fbs_back
// Executes queued commands on the pixel store and holds the result word
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module fbs_back import fbs_pkg::*; #(
  parameter int unsigned LOW_WIDTH   = 64,
  parameter int unsigned LOW_HEIGHT  = 32,
  parameter int unsigned HIGH_WIDTH  = 128,
  parameter int unsigned HIGH_HEIGHT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  cmd_t                           cmd_i,
  input  logic [$clog2(HIGH_WIDTH)-1:0]  col_i,
  input  logic [$clog2(HIGH_HEIGHT)-1:0] row_i,
  output logic                           cmd_pop_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output res_t                           res_o
);

  localparam int unsigned COL_W = $clog2(HIGH_WIDTH);
  localparam int unsigned ROW_W = $clog2(HIGH_HEIGHT);
  localparam int unsigned CMP_W = ROW_W + 4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PIX  = 5'b00010,
    S_SRD  = 5'b00100,
    S_SWR  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  cmd_t                    cmd_q, cmd_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [ROW_W-1:0]        cnt_q, cnt_d;
  logic [HIGH_HEIGHT-1:0]  valid_q, valid_d;
  res_t                    res_q, res_d;
  res_t                    out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    ram_wen, ram_ren;
  logic [ROW_W-1:0]        ram_waddr, ram_raddr;
  logic [HIGH_WIDTH-1:0]   ram_wdata, ram_rdata;

  logic [HIGH_WIDTH-1:0]   lo_mask;
  logic [HIGH_WIDTH-1:0]   base;
  logic [ROW_W-1:0]        src;
  logic [ROW_W-1:0]        top_row;
  logic                    src_ok;
  logic                    pix;
  logic                    out_free;
  logic                    fin;
  res_t                    fin_res;

  fbs_ram #(
    .WIDTH (HIGH_WIDTH),
    .DEPTH (HIGH_HEIGHT)
  ) u_ram (
    .clk_i   (clk_i),
    .wen_i   (ram_wen),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .ren_i   (ram_ren),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < HIGH_WIDTH; i++) begin
      lo_mask[i] = (i < LOW_WIDTH);
    end
  end

  assign out_free = !out_valid_q || res_ready_i;
  assign top_row  = cmd_i.hr ? ROW_W'(HIGH_HEIGHT - 1) : ROW_W'(LOW_HEIGHT - 1);
  assign src_ok   = (cmd_q.kind != KIND_SDOWN) || (CMP_W'(cnt_q) >= CMP_W'(cmd_q.rows));
  assign src      = (cmd_q.kind == KIND_SDOWN) ?
                    ROW_W'(CMP_W'(cnt_q) - CMP_W'(cmd_q.rows)) : cnt_q;
  assign pix      = base[col_q];

  always_comb begin
    base = '0;
    if (state_q == S_PIX) begin
      base = valid_q[row_q] ? ram_rdata : '0;
    end else if (src_ok && valid_q[src]) begin
      base = ram_rdata;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    ram_ren     = 1'b0;
    ram_raddr   = row_i;
    ram_wen     = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = base;
    fin         = 1'b0;
    fin_res     = '{high_res: cmd_q.hr, pixel_value: 1'b0, collision: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          col_d     = col_i;
          row_d     = row_i;
          ram_ren   = 1'b1;
          fin_res   = '{high_res: cmd_i.hr, pixel_value: 1'b0, collision: 1'b0};
          unique case (cmd_i.kind)
            KIND_TOGGLE, KIND_READ: state_d = S_PIX;
            KIND_CLEAR, KIND_HIGHRES, KIND_LOWRES: begin
              valid_d = '0;
              fin     = 1'b1;
            end
            KIND_SDOWN: begin
              if (cmd_i.rows == 4'd0) begin
                fin = 1'b1;
              end else begin
                cnt_d   = top_row;
                state_d = S_SRD;
              end
            end
            KIND_SLEFT, KIND_SRIGHT: begin
              cnt_d   = top_row;
              state_d = S_SRD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PIX: begin
        fin_res.collision   = (cmd_q.kind == KIND_TOGGLE) && pix;
        fin_res.pixel_value = (cmd_q.kind == KIND_READ) && pix;
        fin                 = 1'b1;
        if (cmd_q.kind == KIND_TOGGLE) begin
          ram_wen          = 1'b1;
          ram_waddr        = row_q;
          ram_wdata        = base;
          ram_wdata[col_q] = !pix;
          valid_d[row_q]   = 1'b1;
        end
      end
      S_SRD: begin
        ram_ren   = 1'b1;
        ram_raddr = src;
        state_d   = S_SWR;
      end
      S_SWR: begin
        ram_wen        = 1'b1;
        ram_waddr      = cnt_q;
        valid_d[cnt_q] = 1'b1;
        unique case (cmd_q.kind)
          KIND_SLEFT:  ram_wdata = base >> SHIFT_COLS;
          KIND_SRIGHT: ram_wdata = cmd_q.hr ? (base << SHIFT_COLS)
                                            : ((base << SHIFT_COLS) & lo_mask);
          default:     ram_wdata = base;
        endcase
        if (cnt_q == '0) begin
          fin = 1'b1;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_SRD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      res_d   = fin_res;
      state_d = out_free ? S_IDLE : S_OUT;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (fin && out_free) begin
      out_d       = fin_res;
      out_valid_d = 1'b1;
    end else if ((state_q == S_OUT) && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    col_q <= col_d;
    row_q <= row_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ===== sv/xor_framebuffer_with_scroll.sv =====
// ----------------------------------------------------------------------------
// xor_framebuffer_with_scroll
// Monochrome framebuffer with two resolutions, pixel toggle with collision
// report, pixel read, clear and row/column scrolling.
//
// Channel   Direction  tdata (lowest bit up)            tuser
// s_axis    in         x[7:0], y[7:0], scroll_rows[3:0]  kind[2:0]
// m_axis    out        collision, pixel_value, high_res  -
//
// Toggle and read do a row read and, for a toggle, a row write. Clear,
// resolution commands and a scroll down by zero rows finish straight from the idle state;
// other scrolls do one read and one write per row of the area.
// Reset clears the per-row valid flags at once, so no clearing pass runs.
// A two-entry command queue and the output register let the input keep accepting,
// until the queue is full, while a result waits or a scroll is under way.
// ----------------------------------------------------------------------------
module xor_framebuffer_with_scroll import fbs_pkg::*; #(
  parameter int unsigned LOW_WIDTH   = 64,
  parameter int unsigned LOW_HEIGHT  = 32,
  parameter int unsigned HIGH_WIDTH  = 128,
  parameter int unsigned HIGH_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // x[7:0], y[15:8], scroll_rows[19:16]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // collision[0], pixel_value[1], high_res[2]
);

  localparam int unsigned COL_W   = $clog2(HIGH_WIDTH);
  localparam int unsigned ROW_W   = $clog2(HIGH_HEIGHT);
  localparam int unsigned CMD_W   = $bits(cmd_t);
  localparam int unsigned Q_WIDTH = COL_W + ROW_W + CMD_W;
  localparam int unsigned Q_DEPTH = 2;

  logic             push, full, empty, pop;
  cmd_t             f_cmd, b_cmd;
  logic [COL_W-1:0] f_col, b_col;
  logic [ROW_W-1:0] f_row, b_row;
  logic [Q_WIDTH-1:0] q_din, q_dout;
  res_t             res;

  fbs_front #(
    .LOW_WIDTH   (LOW_WIDTH),
    .LOW_HEIGHT  (LOW_HEIGHT),
    .HIGH_WIDTH  (HIGH_WIDTH),
    .HIGH_HEIGHT (HIGH_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .room_i  (!full),
    .kind_i  (s_axis_tuser),
    .x_i     (s_axis_tdata[7:0]),
    .y_i     (s_axis_tdata[15:8]),
    .rows_i  (s_axis_tdata[19:16]),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .cmd_o   (f_cmd),
    .col_o   (f_col),
    .row_o   (f_row)
  );

  assign q_din = {f_col, f_row, f_cmd};

  fbs_fifo #(
    .WIDTH (Q_WIDTH),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_col, b_row, b_cmd} = q_dout;

  fbs_back #(
    .LOW_WIDTH   (LOW_WIDTH),
    .LOW_HEIGHT  (LOW_HEIGHT),
    .HIGH_WIDTH  (HIGH_WIDTH),
    .HIGH_HEIGHT (HIGH_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (b_cmd),
    .col_i       (b_col),
    .row_i       (b_row),
    .cmd_pop_o   (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'b0, res};

endmodule
